@@ rtl/array_bst_insert_delete_unit_macros.svh @@
// Assertion macros for the array BST insert/delete unit.
// Included by the top level only; depends on nothing else.
`ifndef ARRAY_BST_INSERT_DELETE_UNIT_MACROS_SVH
`define ARRAY_BST_INSERT_DELETE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ABID_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define ABID_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/abid_pkg.sv @@
// Shared types, constants and helpers for the array BST insert/delete unit.
// Used by the interfaces, the engine and the top level; depends on nothing.
`default_nettype none

package abid_pkg;

    // Tree geometry and key width.
    localparam int SLOTS        = 128;
    localparam int KEY_WIDTH    = 16;
    localparam int SLOT_W       = $clog2(SLOTS);
    localparam int IDX_W        = SLOT_W + 1;
    localparam int SLOT_FIELD_W = 7;
    localparam int STATUS_W     = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_NOT_FOUND = 2'd2
    } t_status;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } t_op;

    typedef logic [IDX_W-1:0]     t_idx;
    typedef logic [KEY_WIDTH-1:0] t_key;

    // Key memory access request from the engine.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        t_key              wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } t_mem_req;

    // Finished result offered by the engine to the output register.
    typedef struct packed {
        logic                    valid;
        t_status                 status;
        logic [SLOT_FIELD_W-1:0] slot;
    } t_result;

    // Left child of slot s.
    function automatic t_idx left_of(input t_idx s);
        return {s[IDX_W-2:0], 1'b0};
    endfunction

    // Right child of slot s.
    function automatic t_idx right_of(input t_idx s);
        return {s[IDX_W-2:0], 1'b1};
    endfunction

    // Slot number as reported on the result channel.
    function automatic logic [SLOT_FIELD_W-1:0] slot_field(input t_idx s);
        return SLOT_FIELD_W'(s);
    endfunction

endpackage

`default_nettype wire

@@ rtl/abid_req_if.sv @@
// Request channel interface: operation and key with a valid/ready handshake.
// Depends on abid_pkg.
`default_nettype none

interface abid_req_if import abid_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic                 op;
    logic [KEY_WIDTH-1:0] key;

    modport source (output valid, output op, output key, input ready);
    modport sink (input valid, input op, input key, output ready);

endinterface

`default_nettype wire

@@ rtl/abid_rsp_if.sv @@
// Response channel interface: status and slot with a valid/ready handshake.
// Depends on abid_pkg.
`default_nettype none

interface abid_rsp_if import abid_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic [STATUS_W-1:0]     status;
    logic [SLOT_FIELD_W-1:0] slot;

    modport source (output valid, output status, output slot, input ready);
    modport sink (input valid, input status, input slot, output ready);

endinterface

`default_nettype wire

@@ rtl/abid_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
`default_nettype none

module abid_ram #(
    parameter int DEPTH = 128,
    parameter int WIDTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, registered.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/abid_engine.sv @@
// Tree walk and delete cascade sequencer with the per-slot valid bits.
// Depends on abid_pkg and abid_req_if; drives the key RAM through t_mem_req.
`default_nettype none

module abid_engine import abid_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    abid_req_if.sink  i_req,
    input  wire t_key i_rdata,
    input  wire logic i_can_post,
    output t_mem_req  o_mem,
    output t_result   o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_CMP,
        S_CASC,
        S_SMIN,
        S_SMAX,
        S_MOVE,
        S_RESULT
    } t_state;

    t_state                  r_state, n_state;
    logic [SLOTS-1:0]        r_valid, n_valid;
    t_op                     r_op, n_op;
    t_key                    r_key, n_key;
    t_idx                    r_cur, n_cur;
    t_idx                    r_src, n_src;
    t_idx                    r_found, n_found;
    t_status                 r_status, n_status;
    logic [SLOT_FIELD_W-1:0] r_slot, n_slot;

    // A slot holds a key when it lies inside the array and is marked valid.
    function automatic logic occ(input t_idx s, input logic [SLOTS-1:0] v);
        return (s < t_idx'(SLOTS)) && v[s[SLOT_W-1:0]];
    endfunction

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_res.valid  = (r_state == S_RESULT);
    assign o_res.status = r_status;
    assign o_res.slot   = r_slot;

    // Next state, valid bit updates and key RAM requests.
    always_comb begin
        n_state  = r_state;
        n_valid  = r_valid;
        n_op     = r_op;
        n_key    = r_key;
        n_cur    = r_cur;
        n_src    = r_src;
        n_found  = r_found;
        n_status = r_status;
        n_slot   = r_slot;
        o_mem    = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_req.valid) begin
                    n_op    = t_op'(i_req.op);
                    n_key   = i_req.key;
                    n_cur   = t_idx'(1);
                    n_state = S_WALK;
                end
            end

            // Look at the current slot; fetch its key if the walk goes on.
            S_WALK: begin
                if (r_op == OP_INSERT) begin
                    if (r_cur >= t_idx'(SLOTS)) begin
                        n_status = ST_OVERFLOW;
                        n_slot   = '0;
                        n_state  = S_RESULT;
                    end else if (!r_valid[r_cur[SLOT_W-1:0]]) begin
                        o_mem.we                   = 1'b1;
                        o_mem.waddr                = r_cur[SLOT_W-1:0];
                        o_mem.wdata                = r_key;
                        n_valid[r_cur[SLOT_W-1:0]] = 1'b1;
                        n_status                   = ST_DONE;
                        n_slot                     = slot_field(r_cur);
                        n_state                    = S_RESULT;
                    end else begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = r_cur[SLOT_W-1:0];
                        n_state     = S_CMP;
                    end
                end else begin
                    if (!occ(r_cur, r_valid)) begin
                        n_status = ST_NOT_FOUND;
                        n_slot   = '0;
                        n_state  = S_RESULT;
                    end else begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = r_cur[SLOT_W-1:0];
                        n_state     = S_CMP;
                    end
                end
            end

            // Compare with the stored key; equal keys go right.
            S_CMP: begin
                if ((r_op == OP_DELETE) && (i_rdata == r_key)) begin
                    n_found = r_cur;
                    n_state = S_CASC;
                end else begin
                    n_cur   = (r_key < i_rdata) ? left_of(r_cur) : right_of(r_cur);
                    n_state = S_WALK;
                end
            end

            // Choose the replacement source, or free the slot if it is a leaf.
            S_CASC: begin
                if (occ(right_of(r_cur), r_valid)) begin
                    n_src   = right_of(r_cur);
                    n_state = S_SMIN;
                end else if (occ(left_of(r_cur), r_valid)) begin
                    n_src   = left_of(r_cur);
                    n_state = S_SMAX;
                end else begin
                    n_valid[r_cur[SLOT_W-1:0]] = 1'b0;
                    n_status                   = ST_DONE;
                    n_slot                     = slot_field(r_found);
                    n_state                    = S_RESULT;
                end
            end

            // Descend to the leftmost slot of the right subtree.
            S_SMIN: begin
                if (occ(left_of(r_src), r_valid)) begin
                    n_src = left_of(r_src);
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_src[SLOT_W-1:0];
                    n_state     = S_MOVE;
                end
            end

            // Descend to the rightmost slot of the left subtree.
            S_SMAX: begin
                if (occ(right_of(r_src), r_valid)) begin
                    n_src = right_of(r_src);
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_src[SLOT_W-1:0];
                    n_state     = S_MOVE;
                end
            end

            // Copy the source key up and continue the cascade at the source.
            S_MOVE: begin
                o_mem.we    = 1'b1;
                o_mem.waddr = r_cur[SLOT_W-1:0];
                o_mem.wdata = i_rdata;
                n_cur       = r_src;
                n_state     = S_CASC;
            end

            S_RESULT: begin
                if (i_can_post) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State, valid bits and registered result.
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_key    <= n_key;
        r_cur    <= n_cur;
        r_src    <= n_src;
        r_found  <= n_found;
        r_status <= n_status;
        r_slot   <= n_slot;
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
        end
    end

endmodule

`default_nettype wire

@@ rtl/array_bst_insert_delete_unit.sv @@
// Array BST insert/delete unit: a binary search tree held in a slot array
// (root at slot 1, children of slot i at 2i and 2i+1).
// Requests arrive on i_req (op: 0 insert, 1 delete; key) and each one yields
// exactly one response on o_rsp (status: 0 done, 1 overflow, 2 not found;
// slot written by insert or slot where delete found the key, 0 on failure).
// Both channels use valid/ready; a request or response moves on a clock edge
// where both are high. One request is worked on at a time.
// Keys live in a RAM with a registered read port; the valid bit of each
// slot sits in flip-flops. Each tree level visited is a RAM read then a
// compare. An insert walks down to the first free slot on its path (root is
// level 0) and writes its key there; an insert that runs past the deepest
// level, 6, reports an overflow. A delete first finds the key, then for every
// cascade step picks a side, descends through the successor search and moves
// the key up; at last it frees the leaf and posts the response.
// A new request is taken in the cycle after the previous response is handed
// to the output register, so a stalled receiver holds at most one response
// there while the next request is processed.
// Reset (synchronous, active low) empties the tree at once; no clearing pass.
`default_nettype none

`include "array_bst_insert_delete_unit_macros.svh"

module array_bst_insert_delete_unit import abid_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    abid_req_if.sink   i_req,
    abid_rsp_if.source o_rsp
);

    t_mem_req                w_mem;
    t_result                 w_res;
    t_key                    w_rdata;
    logic                    w_can_post;
    logic                    w_req_take;
    logic                    w_res_post;
    logic                    w_res_fail;
    logic                    r_out_valid;
    logic [STATUS_W-1:0]     r_out_status;
    logic [SLOT_FIELD_W-1:0] r_out_slot;

    // Tree walk and delete cascade.
    abid_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_rdata    (w_rdata),
        .i_can_post (w_can_post),
        .o_mem      (w_mem),
        .o_res      (w_res)
    );

    // Key storage.
    abid_ram #(
        .DEPTH (SLOTS),
        .WIDTH (KEY_WIDTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_rdata)
    );

    // Output register: takes a result when empty or being drained.
    assign w_can_post = !r_out_valid || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (w_res.valid && w_can_post) begin
            r_out_status <= w_res.status;
            r_out_slot   <= w_res.slot;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res.valid && w_can_post) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_rsp.valid  = r_out_valid;
    assign o_rsp.status = r_out_status;
    assign o_rsp.slot   = r_out_slot;

    // Handshake and result conditions watched by the checks below.
    assign w_req_take = i_req.valid && i_req.ready;
    assign w_res_post = w_res.valid && w_can_post;
    assign w_res_fail = w_res.valid && (w_res.status != ST_DONE);

    // Only one request is in flight: the unit goes busy right after accepting.
    `ABID_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_req_take, !i_req.ready, "request taken while busy")

    // A result handed over always lands in the output register.
    `ABID_ASSERT_NXT(a_result_lands, i_clk, i_rst_n, w_res_post, r_out_valid, "result lost")

    // A failed operation reports slot zero.
    `ABID_ASSERT_IMP(a_fail_slot_zero, i_clk, i_rst_n, w_res_fail, w_res.slot == '0, "bad fail slot")

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for array_bst_insert_delete_unit: a clocked driver and
// monitor around a shadow tree that predicts every response.
// Depends on abid_pkg and the abid_req_if / abid_rsp_if interfaces.

module tb_top;
    import abid_pkg::*;

    localparam int HOLD_CYCLES  = 300;
    localparam int STALL_LIMIT  = 5000;
    localparam int PHASE_ITEMS  = 370;
    localparam int SETTLE_CYCLES = 40;

    typedef struct {
        t_op  op;
        t_key key;
    } bst_request_t;

    typedef struct {
        t_status                 status;
        logic [SLOT_FIELD_W-1:0] slot;
    } bst_response_t;

    logic i_clk;
    logic i_rst_n;

    abid_req_if req_if ();
    abid_rsp_if rsp_if ();

    array_bst_insert_delete_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the tree, updated as each request is accepted.
    t_key tree_key  [SLOTS];
    bit   tree_used [SLOTS];

    bst_request_t  req_pending[$];
    bst_response_t rsp_expected[$];
    t_key          live_keys[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_seq       = 0;
    int hold_seen;
    int hold_left;
    int requests_taken = 0;
    int idle_cycles    = 0;
    int error_count    = 0;

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic bit slot_taken(int s);
        return (s < SLOTS) && tree_used[s];
    endfunction

    // Apply one request to the shadow tree and return the response it yields.
    function automatic bst_response_t bst_apply(bst_request_t r);
        bst_response_t rsp;
        int s;
        int src;
        int found;
        rsp.status = ST_DONE;
        rsp.slot   = '0;
        s = 1;
        if (r.op == OP_INSERT) begin
            // Equal keys go right; the first empty slot on the path takes the key.
            while (slot_taken(s))
                s = (r.key < tree_key[s]) ? 2 * s : 2 * s + 1;
            if (s < SLOTS) begin
                tree_key[s]  = r.key;
                tree_used[s] = 1'b1;
                rsp.slot     = SLOT_FIELD_W'(s);
            end else begin
                rsp.status = ST_OVERFLOW;
            end
            return rsp;
        end
        while (slot_taken(s) && tree_key[s] != r.key)
            s = (r.key < tree_key[s]) ? 2 * s : 2 * s + 1;
        if (!slot_taken(s)) begin
            rsp.status = ST_NOT_FOUND;
            return rsp;
        end
        found = s;
        // Pull successors (or predecessors) up until a leaf can be cleared.
        while (1) begin
            if (slot_taken(2 * s + 1)) begin
                src = 2 * s + 1;
                while (slot_taken(2 * src))
                    src = 2 * src;
            end else if (slot_taken(2 * s)) begin
                src = 2 * s;
                while (slot_taken(2 * src + 1))
                    src = 2 * src + 1;
            end else begin
                tree_used[s] = 1'b0;
                break;
            end
            tree_key[s] = tree_key[src];
            s = src;
        end
        rsp.slot = SLOT_FIELD_W'(found);
        return rsp;
    endfunction

    // Queue a request and keep a rough list of keys that should be in the tree.
    task automatic queue_request(t_op op, t_key key);
        bst_request_t r;
        r.op  = op;
        r.key = key;
        req_pending.push_back(r);
        if (op == OP_INSERT) begin
            live_keys.push_back(key);
        end else begin
            foreach (live_keys[i]) begin
                if (live_keys[i] == key) begin
                    live_keys.delete(i);
                    break;
                end
            end
        end
    endtask

    // Mostly inserts and deletes of keys already stored, with some noise.
    task automatic queue_random_requests(int count);
        int   ins_pct;
        int   sel;
        t_key k;
        repeat (count) begin
            ins_pct = (live_keys.size() < 8) ? 80 : (live_keys.size() < 20) ? 55 : 30;
            if (live_keys.size() == 0 || $urandom_range(99) < ins_pct) begin
                sel = $urandom_range(9);
                if (sel < 2)
                    k = t_key'($urandom_range(15));
                else if (sel == 2)
                    k = $urandom_range(1) ? '1 : '0;
                else
                    k = t_key'($urandom);
                queue_request(OP_INSERT, k);
            end else begin
                sel = $urandom_range(9);
                if (sel < 8)
                    k = live_keys[$urandom_range(live_keys.size() - 1)];
                else if (sel == 8)
                    k = t_key'($urandom);
                else
                    k = t_key'($urandom_range(15));
                queue_request(OP_DELETE, k);
            end
        end
    endtask

    task automatic wait_for_drain();
        while (req_pending.size() != 0 || rsp_expected.size() != 0)
            @(posedge i_clk);
    endtask

    // Request driver: holds the head request until it is taken.
    always @(posedge i_clk) begin : req_driver
        bit offering;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.op    <= OP_INSERT;
            req_if.key   <= '0;
        end else begin
            offering = req_if.valid;
            if (req_if.valid && req_if.ready) begin
                rsp_expected.push_back(bst_apply(req_pending.pop_front()));
                requests_taken++;
                offering = 1'b0;
            end
            if (!offering) begin
                if (req_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_if.valid <= 1'b1;
                    req_if.op    <= req_pending[0].op;
                    req_if.key   <= req_pending[0].key;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Response monitor: checks each response and drives ready, with long holds on request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            hold_seen    <= 0;
            hold_left    <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                if (rsp_expected.size() == 0) begin
                    $display("%0t: unexpected response, status %0d slot %0d",
                             $time, rsp_if.status, rsp_if.slot);
                    error_count++;
                end else begin
                    if (rsp_if.status !== rsp_expected[0].status) begin
                        $display("%0t: status mismatch, expected %0d actual %0d",
                                 $time, rsp_expected[0].status, rsp_if.status);
                        error_count++;
                    end
                    if (rsp_if.slot !== rsp_expected[0].slot) begin
                        $display("%0t: slot mismatch, expected %0d actual %0d",
                                 $time, rsp_expected[0].slot, rsp_if.slot);
                        error_count++;
                    end
                    void'(rsp_expected.pop_front());
                end
            end
            if (hold_seen != hold_seq) begin
                hold_seen    <= hold_seq;
                hold_left    <= HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Count cycles in which neither channel moves anything.
    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        wait (i_rst_n === 1'b1);
        while (idle_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("TEST FAILED");
        $finish;
    end

    // Main sequence: reset, directed requests, then random phases with varied idling.
    initial begin
        int send_pct [4] = '{0, 76, 0, 30};
        int recv_pct [4] = '{0, 0, 76, 30};
        req_if.valid = 1'b0;
        req_if.op    = OP_INSERT;
        req_if.key   = '0;
        rsp_if.ready = 1'b0;
        i_rst_n      = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A chain of equal maximum keys runs down the right edge and overflows.
        repeat (8) queue_request(OP_INSERT, '1);
        // Deleting the root walks the whole chain.
        queue_request(OP_DELETE, '1);
        queue_request(OP_DELETE, '0);
        // Left side: a node with a right child, then one with only a left child.
        queue_request(OP_INSERT, '0);
        queue_request(OP_INSERT, 16'd1);
        queue_request(OP_DELETE, '0);
        queue_request(OP_INSERT, '0);
        queue_request(OP_DELETE, 16'd1);
        queue_request(OP_INSERT, 16'h5555);
        queue_request(OP_INSERT, 16'hAAAA);
        queue_request(OP_DELETE, 16'h5555);
        repeat (3) queue_request(OP_DELETE, '1);
        queue_request(OP_DELETE, '0);
        queue_request(OP_DELETE, '0);
        queue_request(OP_DELETE, 16'hAAAA);

        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = send_pct[phase];
            recv_stall_pct = recv_pct[phase];
            queue_random_requests(PHASE_ITEMS);
            if (phase == 0) begin
                // Stall the receiver while plenty of requests are still offered.
                wait (requests_taken >= 60);
                hold_seq++;
            end
            wait_for_drain();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/abid_pkg.sv
rtl/abid_req_if.sv
rtl/abid_rsp_if.sv
rtl/abid_ram.sv
rtl/abid_engine.sv
rtl/array_bst_insert_delete_unit.sv
tb/sv/tb_top.sv
